// File: design/md_message_padder_defines.svh
// assertion macros for the message padder checker
`ifndef MD_MESSAGE_PADDER_DEFINES_SVH
`define MD_MESSAGE_PADDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MDP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("message padder check failed");

// next-cycle implication, checked outside reset
`define MDP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("message padder check failed");

`endif

// File: design/mdp_pkg.sv
// types and constants shared by the message padder modules
package mdp_pkg;

	localparam int unsigned COUNT_W = 61;
	localparam int unsigned BLOCKS_W = 56;
	localparam int unsigned TOTAL_W = 5;

	localparam logic [TOTAL_W-1:0] WORDS_PER_BLOCK = 5'd16;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [2:0] LENGTH_ROW = 3'd7;
	localparam logic [COUNT_W:0] LENGTH_BYTES = 62'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic end_of_message;
	} req_t;

	typedef struct packed {
		logic [31:0] word;
		logic last_word;
		logic [BLOCKS_W-1:0] block_count;
	} rsp_t;

	typedef struct packed {
		logic is_end;
		logic [31:0] word;
		logic [COUNT_W-1:0] count;
		logic [TOTAL_W-1:0] total;
		logic [BLOCKS_W-1:0] blocks;
	} entry_t;

	typedef struct packed {
		logic valid;
		entry_t entry;
	} q_port_t;

endpackage

// File: design/mdp_front.sv
// front end: packs bytes into words and classifies end requests
module mdp_front (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input mdp_pkg::req_t req,
	input logic full,
	output logic req_stall,
	output mdp_pkg::q_port_t push
);

	logic [mdp_pkg::COUNT_W-1:0] cnt_q;
	logic [23:0] part_q;
	logic accept;
	logic [1:0] pos;
	logic [31:0] pad_word;
	logic [mdp_pkg::COUNT_W:0] len_sum;
	logic [mdp_pkg::TOTAL_W-1:0] total;

	assign req_stall = full;
	assign accept = req_valid && !full;
	assign pos = cnt_q[1:0];
	assign len_sum = {1'b0, cnt_q} + mdp_pkg::LENGTH_BYTES;

	always_comb begin
		case (pos)
			2'd0: pad_word = {24'd0, mdp_pkg::PAD_MARK};
			2'd1: pad_word = {16'd0, mdp_pkg::PAD_MARK, part_q[7:0]};
			2'd2: pad_word = {8'd0, mdp_pkg::PAD_MARK, part_q[15:0]};
			default: pad_word = {mdp_pkg::PAD_MARK, part_q};
		endcase
	end

	always_comb begin
		total = mdp_pkg::WORDS_PER_BLOCK - {1'b0, cnt_q[5:2]};
		if (cnt_q[5:3] == mdp_pkg::LENGTH_ROW) begin
			total = total + mdp_pkg::WORDS_PER_BLOCK;
		end
	end

	always_comb begin
		push.valid = 1'b0;
		push.entry.is_end = 1'b0;
		push.entry.word = {req.data_byte, part_q};
		push.entry.count = cnt_q;
		push.entry.total = total;
		push.entry.blocks = len_sum[mdp_pkg::COUNT_W:6] + 56'd1;
		if (accept) begin
			if (req.end_of_message) begin
				push.valid = 1'b1;
				push.entry.is_end = 1'b1;
				push.entry.word = pad_word;
			end else if (pos == 2'd3) begin
				push.valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			part_q <= '0;
		end else if (accept) begin
			if (req.end_of_message) begin
				cnt_q <= '0;
				part_q <= '0;
			end else begin
				cnt_q <= cnt_q + 61'd1;
				case (pos)
					2'd0: part_q <= {16'd0, req.data_byte};
					2'd1: part_q <= {8'd0, req.data_byte, part_q[7:0]};
					2'd2: part_q <= {req.data_byte, part_q[15:0]};
					default: part_q <= '0;
				endcase
			end
		end
	end

endmodule

// File: design/mdp_queue.sv
// short fifo of classified entries between front and back
module mdp_queue #(
	parameter int unsigned DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input mdp_pkg::q_port_t push,
	input logic pop,
	output logic full,
	output mdp_pkg::q_port_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	mdp_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign do_push = push.valid && !full;
	assign do_pop = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: design/mdp_back.sv
// back end: expands entries into padded words behind an output register
module mdp_back (
	input logic clk,
	input logic arst_n,
	input mdp_pkg::q_port_t head,
	output logic pop,
	output logic rsp_valid,
	input logic rsp_stall,
	output mdp_pkg::rsp_t rsp
);

	logic [mdp_pkg::TOTAL_W-1:0] idx_q;
	logic rsp_valid_q;
	mdp_pkg::rsp_t rsp_q;
	mdp_pkg::rsp_t next_rsp;
	logic advance;
	logic produce;
	logic at_last;
	logic at_len_lo;

	assign advance = !rsp_valid_q || !rsp_stall;
	assign produce = head.valid && advance;
	assign at_last = (idx_q == head.entry.total - 5'd1);
	assign at_len_lo = (idx_q == head.entry.total - 5'd2);
	assign pop = produce && (!head.entry.is_end || at_last);

	always_comb begin
		next_rsp.word = '0;
		next_rsp.last_word = 1'b0;
		next_rsp.block_count = '0;
		if (!head.entry.is_end) begin
			next_rsp.word = head.entry.word;
		end else if (at_last) begin
			next_rsp.word = head.entry.count[60:29];
			next_rsp.last_word = 1'b1;
			next_rsp.block_count = head.entry.blocks;
		end else if (at_len_lo) begin
			next_rsp.word = {head.entry.count[28:0], 3'b000};
		end else if (idx_q == '0) begin
			next_rsp.word = head.entry.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				idx_q <= '0;
			end else if (produce) begin
				idx_q <= idx_q + 5'd1;
			end
			if (advance) begin
				rsp_valid_q <= head.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			rsp_q <= next_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// File: design/md_message_padder.sv
// top level of the md5-style message padder
//
// requests carry one message byte each, or an end marker that closes the
// message. bytes pack into 32-bit words, earliest byte in bits 7..0, and a
// word leaves as soon as its fourth byte is in. after an end request the
// block sends the partial word with 0x80 appended, zero words and the
// 64-bit bit length (low word first), 3 to 18 words filling whole 64-byte
// blocks; the final word has last_word set and carries the block count.
// a byte request is taken every cycle while the entry queue has room; a
// word is registered in the entry queue and then in the output register
// before it shows on rsp. the padding of one message goes out at one word
// per cycle while rsp_stall is low, set by the single output register of
// the back end; the front takes next-message bytes until QUEUE_DEPTH entries wait.
// reset clears the byte count, the partial word, the queue and rsp_valid.
// while rsp_stall is high the shown word holds, the back end waits and
// req_stall rises once the queue is full.
module md_message_padder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input mdp_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output mdp_pkg::rsp_t rsp
);

	mdp_pkg::q_port_t push;
	mdp_pkg::q_port_t head;
	logic full;
	logic pop;

	mdp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.full(full),
		.req_stall(req_stall),
		.push(push)
	);

	mdp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.full(full),
		.head(head)
	);

	mdp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule

// File: design/mdp_checker.sv
// port-level checker for the message padder, bound to the top level
`include "md_message_padder_defines.svh"

module mdp_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input mdp_pkg::req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input mdp_pkg::rsp_t rsp
);

	`MDP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`MDP_ASSERT_NOW(a_count_only_last, rsp_valid && !rsp.last_word, rsp.block_count == '0)
	`MDP_ASSERT_NOW(a_last_has_blocks, rsp_valid && rsp.last_word, rsp.block_count != '0)

endmodule

bind md_message_padder mdp_checker u_mdp_checker (.*);

// File: sim/md_message_padder_checker.sv
// checker for the message padder: predicts the padded words and compares them
module md_message_padder_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input mdp_pkg::req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input mdp_pkg::rsp_t rsp,
	output int errors,
	output int outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_BYTES = 64;

	logic [mdp_pkg::COUNT_W-1:0] msg_bytes;
	logic [23:0] held_bytes;
	mdp_pkg::rsp_t awaited_words[$];
	mdp_pkg::rsp_t head;

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%t: %s", $time, msg);
		end
	endtask

	task automatic push_word(input logic [31:0] w, input logic last,
		input logic [mdp_pkg::BLOCKS_W-1:0] blocks);
		mdp_pkg::rsp_t e;
		e.word = w;
		e.last_word = last;
		e.block_count = blocks;
		awaited_words.push_back(e);
	endtask

	task automatic fold_request(input mdp_pkg::req_t r);
		logic [1:0] pos;
		int rem;
		int total;
		logic [63:0] bits;
		logic [63:0] blocks;
		logic [31:0] w;
		pos = msg_bytes[1:0];
		if (!r.end_of_message) begin
			if (pos == 2'd3) begin
				push_word({r.data_byte, held_bytes}, 1'b0, '0);
				held_bytes = '0;
			end else begin
				held_bytes[pos*8 +: 8] = r.data_byte;
			end
			msg_bytes = msg_bytes + mdp_pkg::COUNT_W'(1);
		end else begin
			rem = int'(msg_bytes[5:0]);
			total = int'(mdp_pkg::WORDS_PER_BLOCK) - rem / 4;
			// length field does not fit behind the mark: one more block
			if (rem >= BLOCK_BYTES - int'(mdp_pkg::LENGTH_BYTES)) begin
				total += int'(mdp_pkg::WORDS_PER_BLOCK);
			end
			bits = {msg_bytes, 3'b000};
			blocks = ({3'b000, msg_bytes} + 64'(mdp_pkg::LENGTH_BYTES)) / 64'(BLOCK_BYTES)
				+ 64'd1;
			for (int i = 0; i < total; i++) begin
				w = (i == 0) ? ({8'h00, held_bytes} | (32'(mdp_pkg::PAD_MARK) << (pos * 8)))
					: 32'h0;
				if (i == total - 2) begin
					w = bits[31:0];
				end
				if (i == total - 1) begin
					push_word(bits[63:32], 1'b1, blocks[mdp_pkg::BLOCKS_W-1:0]);
				end else begin
					push_word(w, 1'b0, '0);
				end
			end
			msg_bytes = '0;
			held_bytes = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_bytes = '0;
			held_bytes = '0;
			awaited_words.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_words.size() == 0) begin
					note_failure($sformatf("unexpected word %h last %b blocks %h",
						rsp.word, rsp.last_word, rsp.block_count));
				end else begin
					head = awaited_words.pop_front();
					if (rsp.word !== head.word || rsp.last_word !== head.last_word ||
						rsp.block_count !== head.block_count) begin
						note_failure($sformatf(
							"mismatch: expected word %h last %b blocks %h, got %h %b %h",
							head.word, head.last_word, head.block_count,
							rsp.word, rsp.last_word, rsp.block_count));
					end
				end
			end
			if (req_valid && !req_stall) begin
				fold_request(req);
			end
			outstanding <= awaited_words.size();
		end
	end

endmodule

// File: sim/tb_md_message_padder.sv
// testbench top for the message padder: request stimulus, back pressure and verdict
module tb_md_message_padder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_AT = 9;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	mdp_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	mdp_pkg::rsp_t rsp;

	int padder_errors;
	int words_pending;
	int msgs_started = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;

	md_message_padder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	md_message_padder_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.errors(padder_errors),
		.outstanding(words_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end
		if (r < 95) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	task automatic send_item(input logic [7:0] d, input logic eom);
		int gap;
		req <= {d, eom};
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_message(input logic [7:0] content[$]);
		no_gaps = ($urandom_range(0, 3) == 0);
		msgs_started <= msgs_started + 1;
		foreach (content[i]) begin
			send_item(content[i], 1'b0);
		end
		// data byte rides along on the end request and must be ignored
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	initial begin
		logic [7:0] msg[$];
		int random_items;
		int len;
		int k;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then short messages with every partial-word position
		msg = {};
		send_message(msg);
		msg = '{8'h00};
		send_message(msg);
		msg = '{8'hFF, 8'h00};
		send_message(msg);
		msg = '{8'hFF, 8'hFF, 8'hFF};
		send_message(msg);
		msg = '{8'hA5, 8'h5A, 8'hFF, 8'h00};
		send_message(msg);
		msg = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10};
		send_message(msg);
		drain();

		random_items = 0;
		k = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (k)
				0: len = 56;
				1: len = 63;
				2: len = 60;
				default: begin
					case ($urandom_range(0, 2))
						0: len = $urandom_range(0, 7);
						1: len = $urandom_range(50, 66);
						default: len = $urandom_range(8, 49);
					endcase
				end
			endcase
			msg = {};
			repeat (len) begin
				case ($urandom_range(0, 9))
					0: msg.push_back(8'h00);
					1: msg.push_back(8'hFF);
					default: msg.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			send_message(msg);
			random_items += len + 1;
			k++;
			if (k == 5) begin
				drain();
			end
		end
		drain();
		repeat (20) @(posedge clk);
		if (padder_errors == 0 && words_pending == 0) begin
			$display("md_message_padder test passed");
		end else begin
			$display("md_message_padder test failed");
		end
		$finish;
	end

	initial begin
		bit held;
		held = 1'b0;
		rsp_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && msgs_started >= HOLD_AT) begin
				// long hold-off while requests keep coming
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 9) < 6) begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b1;
				repeat (idle_len()) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("md_message_padder test failed");
				$finish;
			end
		end
	end

endmodule
